### rtl/lcpr_pkg.sv
// ----------------------------------------------------------------------------
// lcpr_pkg
// Shared types and constants for the lossless context pixel reconstructor.
// ----------------------------------------------------------------------------
package lcpr_pkg;

   localparam int CTX_COUNT_DEF = 365;
   localparam int PIXEL_W       = 8;
   localparam int SYMBOL_W      = 9;
   localparam int CTX_W         = 9;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_ONE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_TWO   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH_THREE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALVING      = 2'd3;

   localparam logic [7:0] THRESH_ONE_RST   = 8'd3;
   localparam logic [7:0] THRESH_TWO_RST   = 8'd7;
   localparam logic [7:0] THRESH_THREE_RST = 8'd21;
   localparam logic [7:0] HALVING_RST      = 8'd64;

   localparam int CTX_WEIGHT_Q0 = 81;
   localparam int CTX_WEIGHT_Q1 = 9;

   typedef struct packed {
      logic [PIXEL_W-1:0]  left_pixel;
      logic [PIXEL_W-1:0]  above_pixel;
      logic [PIXEL_W-1:0]  above_left_pixel;
      logic [PIXEL_W-1:0]  above_right_pixel;
      logic [SYMBOL_W-1:0] mapped_error;
   } req_payload_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_value;
      logic [CTX_W-1:0]   context_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] thresh_one;
      logic [7:0] thresh_two;
      logic [7:0] thresh_three;
   } grad_thresh_type;

   // context choice and prediction for one item
   typedef struct packed {
      logic [CTX_W-1:0]   ctx;
      logic               negative;
      logic [PIXEL_W-1:0] pred;
   } ctx_sel_type;

   // per-context counters A, B, C, N
   typedef struct packed {
      logic [15:0]       a;
      logic signed [8:0] b;
      logic signed [7:0] c;
      logic [7:0]        n;
   } ctx_entry_type;

   localparam int CTX_ENTRY_W = $bits(ctx_entry_type);

   localparam ctx_entry_type CTX_ENTRY_INIT = '{a: 16'd4, b: 9'sd0, c: 8'sd0, n: 8'd1};

endpackage

### rtl/lcpr_ram.sv
// ----------------------------------------------------------------------------
// lcpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcpr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/lcpr_ctx_select.sv
// ----------------------------------------------------------------------------
// lcpr_ctx_select
// Gradient quantization, sign folding to a context number, and the median
// edge predictor.
// ----------------------------------------------------------------------------
module lcpr_ctx_select (
   input  lcpr_pkg::req_payload_type item,
   input  lcpr_pkg::grad_thresh_type thresh,
   output lcpr_pkg::ctx_sel_type     sel
);
   import lcpr_pkg::*;

   function automatic logic signed [3:0] quantize(
      input logic signed [8:0] d,
      input logic [7:0]        t1,
      input logic [7:0]        t2,
      input logic [7:0]        t3
   );
      logic signed [8:0] p1, p2, p3;
      logic signed [3:0] q;
      p1 = $signed({1'b0, t1});
      p2 = $signed({1'b0, t2});
      p3 = $signed({1'b0, t3});
      if (d <= -p3)       q = -4'sd4;
      else if (d <= -p2)  q = -4'sd3;
      else if (d <= -p1)  q = -4'sd2;
      else if (d < 9'sd0) q = -4'sd1;
      else if (d == 9'sd0) q = 4'sd0;
      else if (d < p1)    q = 4'sd1;
      else if (d < p2)    q = 4'sd2;
      else if (d < p3)    q = 4'sd3;
      else                q = 4'sd4;
      return q;
   endfunction

   logic signed [8:0]  d0, d1, d2;
   logic signed [3:0]  q0, q1, q2;
   logic signed [3:0]  f0, f1, f2;
   logic               negative;
   logic signed [10:0] ctx_sum;
   logic [7:0]         lo, hi;
   logic [8:0]         planar;
   logic [7:0]         pred;

   always_comb begin
      d0 = $signed({1'b0, item.above_right_pixel}) - $signed({1'b0, item.above_pixel});
      d1 = $signed({1'b0, item.above_pixel}) - $signed({1'b0, item.above_left_pixel});
      d2 = $signed({1'b0, item.above_left_pixel}) - $signed({1'b0, item.left_pixel});
      q0 = quantize(d0, thresh.thresh_one, thresh.thresh_two, thresh.thresh_three);
      q1 = quantize(d1, thresh.thresh_one, thresh.thresh_two, thresh.thresh_three);
      q2 = quantize(d2, thresh.thresh_one, thresh.thresh_two, thresh.thresh_three);

      // first nonzero gradient decides the sign
      negative = (q0 < 4'sd0) ||
                 (q0 == 4'sd0 && (q1 < 4'sd0 || (q1 == 4'sd0 && q2 < 4'sd0)));
      f0 = negative ? -q0 : q0;
      f1 = negative ? -q1 : q1;
      f2 = negative ? -q2 : q2;
      ctx_sum = 11'(f0) * 11'(CTX_WEIGHT_Q0) + 11'(f1) * 11'(CTX_WEIGHT_Q1) + 11'(f2);

      // median edge predictor
      if (item.left_pixel < item.above_pixel) begin
         lo = item.left_pixel;
         hi = item.above_pixel;
      end else begin
         lo = item.above_pixel;
         hi = item.left_pixel;
      end
      planar = {1'b0, item.left_pixel} + {1'b0, item.above_pixel}
             - {1'b0, item.above_left_pixel};
      if (item.above_left_pixel >= hi)      pred = lo;
      else if (item.above_left_pixel <= lo) pred = hi;
      else                                  pred = planar[7:0];
   end

   assign sel.ctx      = ctx_sum[CTX_W-1:0];
   assign sel.negative = negative;
   assign sel.pred     = pred;

endmodule

### rtl/lcpr_ctx_update.sv
// ----------------------------------------------------------------------------
// lcpr_ctx_update
// Bias-corrected prediction, error unmapping, pixel reconstruction and the
// A/B/C/N counter update for one context.
// ----------------------------------------------------------------------------
module lcpr_ctx_update (
   input  logic [lcpr_pkg::SYMBOL_W-1:0] mapped_error,
   input  lcpr_pkg::ctx_sel_type         sel,
   input  lcpr_pkg::ctx_entry_type       entry,
   input  logic [7:0]                    halving_limit,
   output lcpr_pkg::ctx_entry_type       entry_new,
   output logic [lcpr_pkg::PIXEL_W-1:0]  pixel
);
   import lcpr_pkg::*;

   logic signed [9:0]  c_ext, pred_ext, px_raw;
   logic [7:0]         px;
   logic               k_zero, invert, flip, halve;
   logic signed [9:0]  two_b, neg_n;
   logic [7:0]         half_sym;
   logic signed [9:0]  err, err_signed;
   logic [8:0]         mag;
   logic signed [10:0] b1, b2, b3, b_up, b_dn, n2_ext, neg_n2;
   logic [16:0]        a1;
   logic [15:0]        a_sat, a2;
   logic [7:0]         n_half, n2;
   logic signed [7:0]  c3;

   always_comb begin
      // prediction with bias correction, clamped
      c_ext    = 10'(entry.c);
      pred_ext = $signed({2'b00, sel.pred});
      px_raw   = sel.negative ? pred_ext - c_ext : pred_ext + c_ext;
      if (px_raw < 10'sd0)        px = 8'd0;
      else if (px_raw > 10'sd255) px = 8'd255;
      else                        px = px_raw[7:0];

      // unmap: k is zero when N >= A; inverted mapping if k is zero and 2B <= -N
      k_zero   = {8'd0, entry.n} >= entry.a;
      two_b    = {entry.b[8], entry.b} <<< 1;
      neg_n    = -$signed({2'b00, entry.n});
      invert   = k_zero && (two_b <= neg_n);
      half_sym = mapped_error[8:1];
      flip     = mapped_error[0] ^ invert;
      err      = flip ? $signed(~{2'b00, half_sym}) : $signed({2'b00, half_sym});
      mag      = flip ? {1'b0, half_sym} + 9'd1 : {1'b0, half_sym};

      b1    = 11'(entry.b) + 11'(err);
      a1    = {1'b0, entry.a} + {8'd0, mag};
      a_sat = a1[16] ? 16'hFFFF : a1[15:0];

      halve  = entry.n >= halving_limit;
      a2     = halve ? (a_sat >> 1) : a_sat;
      b2     = halve ? (b1 >>> 1) : b1;
      n_half = halve ? (entry.n >> 1) : entry.n;
      n2     = n_half + 8'd1;

      n2_ext = $signed({3'b000, n2});
      neg_n2 = -n2_ext;
      b_up   = b2 + n2_ext;
      b_dn   = b2 - n2_ext;
      if (b2 <= neg_n2) begin
         b3 = (b_up <= neg_n2) ? neg_n2 + 11'sd1 : b_up;
         c3 = (entry.c == -8'sd128) ? entry.c : entry.c - 8'sd1;
      end else if (b2 > 11'sd0) begin
         b3 = (b_dn > 11'sd0) ? 11'sd0 : b_dn;
         c3 = (entry.c == 8'sd127) ? entry.c : entry.c + 8'sd1;
      end else begin
         b3 = b2;
         c3 = entry.c;
      end

      err_signed = sel.negative ? -err : err;
   end

   assign entry_new.a = a2;
   assign entry_new.b = b3[8:0];
   assign entry_new.c = c3;
   assign entry_new.n = n2;
   assign pixel       = px + err_signed[7:0];

endmodule

### rtl/lossless_context_pixel_reconstructor.sv
// ----------------------------------------------------------------------------
// lossless_context_pixel_reconstructor
// Regular-mode context modeling and pixel reconstruction for 8-bit samples.
// ----------------------------------------------------------------------------
// An accepted item moves to the stage 1 register, then to the result register;
// 1 item per cycle, with req_stall high behind a stalled result or in clearing.
// Context counters live in one RAM, read at accept and written as the item
// moves to the result register; a back-to-back hit on one context is forwarded.
// Reset is synchronous; the RAM is then cleared over all CONTEXT_COUNT entries
// (365 by default) with req_stall high.
// ----------------------------------------------------------------------------
module lossless_context_pixel_reconstructor #(
   parameter int CONTEXT_COUNT = lcpr_pkg::CTX_COUNT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lcpr_pkg::req_payload_type       req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lcpr_pkg::rsp_payload_type       rsp_payload,
   input  logic                            csr_write,
   input  logic [lcpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcpr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcpr_pkg::*;

   localparam int ADDR_W = $clog2(CONTEXT_COUNT);

   // configuration
   grad_thresh_type thresh_ff;
   logic [7:0]      halving_ff;

   // clearing sweep
   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   // stage 1 and forwarding
   logic            s1_valid_ff, s1_valid_in;
   req_payload_type s1_item_ff;
   ctx_sel_type     s1_sel_ff;
   logic            fwd_hit_ff, fwd_hit_in;
   ctx_entry_type   fwd_entry_ff;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   logic            out_free, s1_move, accept;
   ctx_sel_type     sel_new;
   ctx_entry_type   entry_cur, entry_new, ram_rd_entry;
   logic [CTX_ENTRY_W-1:0] ram_rd_data;
   logic            ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   ctx_entry_type   ram_wr_entry;
   logic [PIXEL_W-1:0] pixel_new;

   // ---------------- configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.thresh_one   <= THRESH_ONE_RST;
         thresh_ff.thresh_two   <= THRESH_TWO_RST;
         thresh_ff.thresh_three <= THRESH_THREE_RST;
         halving_ff             <= HALVING_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_THRESH_ONE:   thresh_ff.thresh_one   <= csr_wdata;
            CSR_THRESH_TWO:   thresh_ff.thresh_two   <= csr_wdata;
            CSR_THRESH_THREE: thresh_ff.thresh_three <= csr_wdata;
            CSR_HALVING:      halving_ff             <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = clear_ff || (s1_valid_ff && !out_free);
   assign accept    = req_valid && !req_stall;

   lcpr_ctx_select u_select (
      .item   (req_payload),
      .thresh (thresh_ff),
      .sel    (sel_new)
   );

   // ---------------- context RAM
   always_comb begin
      if (clear_ff) begin
         ram_wr_en    = 1'b1;
         ram_wr_addr  = clear_addr_ff;
         ram_wr_entry = CTX_ENTRY_INIT;
      end else begin
         ram_wr_en    = s1_move;
         ram_wr_addr  = s1_sel_ff.ctx[ADDR_W-1:0];
         ram_wr_entry = entry_new;
      end
   end

   lcpr_ram #(
      .WIDTH (CTX_ENTRY_W),
      .DEPTH (CONTEXT_COUNT)
   ) u_ctx_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (accept),
      .rd_addr (sel_new.ctx[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_entry = ram_rd_data;
   // RAM returns stale data when the previous item wrote the same context
   assign entry_cur    = fwd_hit_ff ? fwd_entry_ff : ram_rd_entry;

   lcpr_ctx_update u_update (
      .mapped_error  (s1_item_ff.mapped_error),
      .sel           (s1_sel_ff),
      .entry         (entry_cur),
      .halving_limit (halving_ff),
      .entry_new     (entry_new),
      .pixel         (pixel_new)
   );

   // ---------------- next-state logic
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(CONTEXT_COUNT - 1)) begin
            clear_in = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      fwd_hit_in = accept && s1_move && (sel_new.ctx == s1_sel_ff.ctx);

      rsp_valid_in = rsp_valid_ff;
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s1_valid_ff   <= s1_valid_in;
         if (accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---------------- payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff   <= req_payload;
         s1_sel_ff    <= sel_new;
         fwd_entry_ff <= entry_new;
      end
      if (s1_move) begin
         rsp_payload_ff.pixel_value   <= pixel_new;
         rsp_payload_ff.context_index <= s1_sel_ff.ctx;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

### rtl/lcpr_checker.sv
// ----------------------------------------------------------------------------
// lcpr_checker
// Port-level checks for the lossless context pixel reconstructor.
// ----------------------------------------------------------------------------
module lcpr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input lcpr_pkg::req_payload_type       req_payload,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input lcpr_pkg::rsp_payload_type       rsp_payload,
   input logic                            csr_write,
   input logic [lcpr_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [lcpr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcpr_pkg::*;

   // RAM clearing follows reset: no item can enter right away
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("item accepted right after reset");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // a rising rsp_valid must trace back to an item that was taken
   a_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching item");

   a_ctx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.context_index <= 9'(CTX_COUNT_DEF - 1)))
      else $error("context index out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

endmodule

bind lossless_context_pixel_reconstructor lcpr_checker u_checker (.*);
